FILE: rtl/bcpp_pkg.sv
package bcpp_pkg;

   // fixed sizes of the pose store
   localparam int MAX_NODES   = 4;
   localparam int NODE_IDX_W  = 2;
   localparam int COORDS      = 6;
   localparam int COORD_IDX_W = 3;
   localparam int ADDR_W      = NODE_IDX_W + COORD_IDX_W;
   localparam int COORD_W     = 32;
   localparam int CNT_W       = 3;
   localparam int MODE_W      = 3;
   localparam int STEP_W      = 25;

   localparam int PHASE_FRAC_BITS_DEF = 24;

   localparam logic [CNT_W-1:0]  NODES_FULL       = CNT_W'(MAX_NODES);
   localparam logic [STEP_W-1:0] PHASE_STEP_RESET = STEP_W'(1024);

   // sequencer counter and the steps of a curve evaluation
   localparam int SEQ_W = 5;
   localparam logic [SEQ_W-1:0] SEQ_UU         = 5'd0;
   localparam logic [SEQ_W-1:0] SEQ_TT         = 5'd1;
   localparam logic [SEQ_W-1:0] SEQ_W0         = 5'd2;
   localparam logic [SEQ_W-1:0] SEQ_W1         = 5'd3;
   localparam logic [SEQ_W-1:0] SEQ_W2         = 5'd4;
   localparam logic [SEQ_W-1:0] SEQ_W3         = 5'd5;
   localparam logic [SEQ_W-1:0] SEQ_UU_DONE    = 5'd1;
   localparam logic [SEQ_W-1:0] SEQ_TT_DONE    = 5'd2;
   localparam logic [SEQ_W-1:0] SEQ_W0_DONE    = 5'd3;
   localparam logic [SEQ_W-1:0] SEQ_W1_DONE    = 5'd4;
   localparam logic [SEQ_W-1:0] SEQ_W2_DONE    = 5'd5;
   localparam logic [SEQ_W-1:0] SEQ_W3_DONE    = 5'd6;
   localparam logic [SEQ_W-1:0] SEQ_RD_FIRST   = 5'd5;
   localparam logic [SEQ_W-1:0] SEQ_RD_LAST    = 5'd28;
   localparam logic [SEQ_W-1:0] SEQ_MAC_FIRST  = 5'd6;
   localparam logic [SEQ_W-1:0] SEQ_ACC_FIRST  = 5'd7;
   localparam logic [SEQ_W-1:0] SEQ_CURVE_LAST = 5'd30;
   localparam logic [SEQ_W-1:0] SEQ_COPY_LAST  = 5'd6;
   localparam logic [SEQ_W-1:0] SEQ_STORE_LAST = 5'd5;

   typedef enum logic [MODE_W-1:0] {
      MODE_STORE  = 3'd0,
      MODE_RECALL = 3'd1,
      MODE_TOGGLE = 3'd2,
      MODE_RESET  = 3'd3,
      MODE_TICK   = 3'd4
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_STORE  = 5'b00010,
      ST_RECALL = 5'b00100,
      ST_CURVE  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   typedef logic signed [COORD_W-1:0] coord_type;

endpackage

FILE: rtl/bcpp_mul.sv
module bcpp_mul #(
   parameter int A_W = bcpp_pkg::COORD_W + 1,
   parameter int B_W = bcpp_pkg::PHASE_FRAC_BITS_DEF + 2
) (
   input  logic                   clock,
   input  logic signed [A_W-1:0]  op_a,
   input  logic        [B_W-1:0]  op_b,
   output logic signed [A_W+B_W:0] prod
);
   import bcpp_pkg::*;

   logic signed [A_W+B_W:0] prod_ff;

   // signed by unsigned, one product per cycle, registered
   always_ff @(posedge clock) begin
      prod_ff <= op_a * $signed({1'b0, op_b});
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/bezier_camera_path_player_unit.sv
// Camera path player: holds up to four camera poses (position and three angles, signed
// Q16.16) and plays a single cubic Bezier segment through them. Each req transfer carries
// a mode: store the given pose, recall node 0, toggle playback, clear the path, or tick.
// A tick while playing advances the phase by csr_phase_step (unsigned, PHASE_FRAC_BITS
// fraction bits) and returns the curve pose; recall returns node 0. Other modes return
// nothing. Toggle, clear, tick while stopped and unused modes stay idle; store writes the
// six coordinates one per cycle into the node memory (one write, one read port); recall
// makes six registered memory reads, then hands over to the rsp register; a playing tick
// is paced by the one shared multiplier: 6 products for the Bernstein weights plus 24
// weighted node products, each followed by a registered accumulate. A finished result is
// held in the rsp register and may wait there while the next item is taken; the block
// holds off a new transfer while its own sequencer is busy, or while a second result waits
// behind one still held in the rsp register. Node memory needs no clearing after reset.
// csr writes are taken at any time and must only be issued while the block is idle.
module bezier_camera_path_player_unit #(
   parameter int PHASE_FRAC_BITS = bcpp_pkg::PHASE_FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bcpp_pkg::MODE_W-1:0]       req_mode,
   input  logic signed [bcpp_pkg::COORD_W-1:0] req_cur_pos_x,
   input  logic signed [bcpp_pkg::COORD_W-1:0] req_cur_pos_y,
   input  logic signed [bcpp_pkg::COORD_W-1:0] req_cur_pos_z,
   input  logic signed [bcpp_pkg::COORD_W-1:0] req_cur_ang_x,
   input  logic signed [bcpp_pkg::COORD_W-1:0] req_cur_ang_y,
   input  logic signed [bcpp_pkg::COORD_W-1:0] req_cur_ang_z,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [bcpp_pkg::COORD_W-1:0] rsp_out_pos_x,
   output logic signed [bcpp_pkg::COORD_W-1:0] rsp_out_pos_y,
   output logic signed [bcpp_pkg::COORD_W-1:0] rsp_out_pos_z,
   output logic signed [bcpp_pkg::COORD_W-1:0] rsp_out_ang_x,
   output logic signed [bcpp_pkg::COORD_W-1:0] rsp_out_ang_y,
   output logic signed [bcpp_pkg::COORD_W-1:0] rsp_out_ang_z,
   output logic                              rsp_pose_source,
   output logic                              rsp_still_playing,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bcpp_pkg::STEP_W-1:0]       csr_phase_step
);
   import bcpp_pkg::*;

   localparam int F       = PHASE_FRAC_BITS;
   localparam int PH_W    = F + 1;              // phase, t, u, uu, tt: 0 .. 1.0
   localparam int WT_W    = F + 2;              // weights up to 3 * 1.0
   localparam int A_W     = COORD_W + 1;
   localparam int PROD_W  = A_W + WT_W + 1;
   localparam int HI_W    = PROD_W - F;
   localparam int SUM_W   = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;

   localparam logic [PH_W-1:0] PHASE_ONE = {1'b1, {F{1'b0}}};
   localparam logic signed [PROD_W-1:0] HALF =
      {{(PROD_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

   // control state
   state_type           state_ff, state_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [CNT_W-1:0]    node_count_ff, node_count_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                playing_ff, playing_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STEP_W-1:0]   phase_step_ff;

   // payload
   coord_type           pose_ff [COORDS];
   coord_type           res_ff  [COORDS];
   logic [PH_W-1:0]     uu_ff, tt_ff;
   logic [WT_W-1:0]     w_ff [MAX_NODES];
   logic signed [PROD_W-1:0] acc_ff;
   logic                src_ff, still_ff;
   coord_type           rsp_coord_ff [COORDS];
   logic                rsp_src_ff, rsp_still_ff;

   // node memory, address = coordinate * 4 + node
   logic [COORD_W-1:0]  node_mem [MAX_NODES*COORDS];
   logic [COORD_W-1:0]  rd_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic                wr_en;

   logic                req_xfer;
   logic                rsp_load;

   // tick and toggle decisions
   logic [SUM_W-1:0]    phase_sum;
   logic                tick_wrap;
   logic                tick_go;
   logic                toggle_play;

   // shared multiplier
   logic signed [A_W-1:0]    op_a;
   logic [WT_W-1:0]          op_b;
   logic signed [PROD_W-1:0] prod;
   logic [PH_W-1:0]          t_val, u_val;
   logic [SEQ_W-1:0]         mac_idx, acc_idx, rd_idx;
   logic [NODE_IDX_W-1:0]    mac_k, acc_k;
   logic [COORD_IDX_W-1:0]   acc_j;
   logic signed [PROD_W-1:0] rnd_sum;
   logic [PH_W-1:0]          rnd_val;
   logic [WT_W-1:0]          rnd_ext, rnd_x3;
   logic signed [PROD_W-1:0] acc_base, mac_sum;
   logic signed [HI_W-1:0]   mac_hi;
   coord_type                mac_sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   assign phase_sum   = SUM_W'(phase_ff) + SUM_W'(phase_step_ff);
   assign tick_wrap   = (phase_sum > SUM_W'(PHASE_ONE));
   assign tick_go     = playing_ff && (node_count_ff >= NODES_FULL);
   assign toggle_play = playing_ff || (node_count_ff >= NODES_FULL);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      node_count_in = node_count_ff;
      phase_in      = phase_ff;
      playing_in    = playing_ff;
      unique case (state_ff)
         ST_IDLE: begin
            seq_in = '0;
            if (req_xfer) begin
               unique case (req_mode)
                  MODE_STORE: begin
                     if (node_count_ff < NODES_FULL) state_in = ST_STORE;
                  end
                  MODE_RECALL: begin
                     if (node_count_ff != '0) state_in = ST_RECALL;
                  end
                  MODE_TOGGLE: begin
                     // a held phase means playback was running: stop and rewind
                     if (toggle_play && (phase_ff != '0)) begin
                        phase_in   = '0;
                        playing_in = 1'b0;
                     end else begin
                        playing_in = toggle_play;
                     end
                  end
                  MODE_RESET: begin
                     node_count_in = '0;
                     phase_in      = '0;
                     playing_in    = 1'b0;
                  end
                  MODE_TICK: begin
                     if (tick_go) begin
                        state_in = ST_CURVE;
                        if (tick_wrap) begin
                           phase_in   = '0;
                           playing_in = 1'b0;
                        end else begin
                           phase_in = phase_sum[PH_W-1:0];
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_STORE: begin
            seq_in = seq_ff + 1'b1;
            if (seq_ff == SEQ_STORE_LAST) begin
               node_count_in = node_count_ff + 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_RECALL: begin
            seq_in = seq_ff + 1'b1;
            if (seq_ff == SEQ_COPY_LAST) state_in = ST_EMIT;
         end
         ST_CURVE: begin
            seq_in = seq_ff + 1'b1;
            if (seq_ff == SEQ_CURVE_LAST) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // rsp register: a new result goes in only once the held one has been transferred
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seq_ff        <= '0;
         node_count_ff <= '0;
         phase_ff      <= '0;
         playing_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_step_ff <= PHASE_STEP_RESET;
      end else begin
         state_ff      <= state_in;
         seq_ff        <= seq_in;
         node_count_ff <= node_count_in;
         phase_ff      <= phase_in;
         playing_ff    <= playing_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) phase_step_ff <= csr_phase_step;
      end
   end

   // ---------------------------------------------------------------- node memory
   assign rd_idx  = seq_ff - SEQ_RD_FIRST;
   assign wr_en   = (state_ff == ST_STORE);
   assign wr_addr = {seq_ff[COORD_IDX_W-1:0], node_count_ff[NODE_IDX_W-1:0]};

   always_comb begin
      if (state_ff == ST_RECALL) begin
         rd_addr = {seq_ff[COORD_IDX_W-1:0], {NODE_IDX_W{1'b0}}};
      end else begin
         rd_addr = rd_idx[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) node_mem[wr_addr] <= pose_ff[seq_ff[COORD_IDX_W-1:0]];
      rd_ff <= node_mem[rd_addr];
   end

   // ---------------------------------------------------------------- multiplier feed
   assign t_val   = phase_ff;
   assign u_val   = PHASE_ONE - phase_ff;
   assign mac_idx = seq_ff - SEQ_MAC_FIRST;
   assign mac_k   = mac_idx[NODE_IDX_W-1:0];

   always_comb begin
      case (seq_ff)
         SEQ_UU: begin
            op_a = {{(A_W-PH_W){1'b0}}, u_val};
            op_b = {1'b0, u_val};
         end
         SEQ_TT: begin
            op_a = {{(A_W-PH_W){1'b0}}, t_val};
            op_b = {1'b0, t_val};
         end
         SEQ_W0: begin
            op_a = {{(A_W-PH_W){1'b0}}, uu_ff};
            op_b = {1'b0, u_val};
         end
         SEQ_W1: begin
            op_a = {{(A_W-PH_W){1'b0}}, uu_ff};
            op_b = {1'b0, t_val};
         end
         SEQ_W2: begin
            op_a = {{(A_W-PH_W){1'b0}}, u_val};
            op_b = {1'b0, tt_ff};
         end
         SEQ_W3: begin
            op_a = {{(A_W-PH_W){1'b0}}, tt_ff};
            op_b = {1'b0, t_val};
         end
         default: begin
            // node coordinate times its weight
            op_a = {rd_ff[COORD_W-1], rd_ff};
            op_b = w_ff[mac_k];
         end
      endcase
   end

   bcpp_mul #(
      .A_W (A_W),
      .B_W (WT_W)
   ) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // ---------------------------------------------------------------- product handling
   // weight terms are non-negative and round half up to PHASE_FRAC_BITS
   assign rnd_sum = prod + HALF;
   assign rnd_val = rnd_sum[F +: PH_W];
   assign rnd_ext = {1'b0, rnd_val};
   assign rnd_x3  = {rnd_val, 1'b0} + rnd_ext;

   assign acc_idx  = seq_ff - SEQ_ACC_FIRST;
   assign acc_k    = acc_idx[NODE_IDX_W-1:0];
   assign acc_j    = acc_idx[NODE_IDX_W +: COORD_IDX_W];
   // first product of a coordinate starts from the rounding offset
   assign acc_base = (acc_k == '0) ? HALF : acc_ff;
   assign mac_sum  = acc_base + prod;
   assign mac_hi   = mac_sum[PROD_W-1:F];   // floor of the scaled sum

   always_comb begin
      if ((mac_hi[HI_W-1:COORD_W-1] == '0) || (mac_hi[HI_W-1:COORD_W-1] == '1)) begin
         mac_sat = mac_hi[COORD_W-1:0];
      end else if (mac_hi[HI_W-1]) begin
         mac_sat = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         mac_sat = {1'b0, {(COORD_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         pose_ff[0] <= req_cur_pos_x;
         pose_ff[1] <= req_cur_pos_y;
         pose_ff[2] <= req_cur_pos_z;
         pose_ff[3] <= req_cur_ang_x;
         pose_ff[4] <= req_cur_ang_y;
         pose_ff[5] <= req_cur_ang_z;
         src_ff     <= (req_mode == MODE_TICK);
         still_ff   <= playing_in;
      end
      if ((state_ff == ST_RECALL) && (seq_ff != '0)) begin
         res_ff[3'(seq_ff - 1'b1)] <= rd_ff;
      end
      if (state_ff == ST_CURVE) begin
         case (seq_ff)
            SEQ_UU_DONE: uu_ff   <= rnd_val;
            SEQ_TT_DONE: tt_ff   <= rnd_val;
            SEQ_W0_DONE: w_ff[0] <= rnd_ext;
            SEQ_W1_DONE: w_ff[1] <= rnd_x3;
            SEQ_W2_DONE: w_ff[2] <= rnd_x3;
            SEQ_W3_DONE: w_ff[3] <= rnd_ext;
            default: begin
               if (seq_ff >= SEQ_ACC_FIRST) begin
                  if (acc_k == NODE_IDX_W'(MAX_NODES - 1)) begin
                     res_ff[acc_j] <= mac_sat;
                  end else begin
                     acc_ff <= mac_sum;
                  end
               end
            end
         endcase
      end
      if (rsp_load) begin
         rsp_coord_ff <= res_ff;
         rsp_src_ff   <= src_ff;
         rsp_still_ff <= still_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_pos_x     = rsp_coord_ff[0];
   assign rsp_out_pos_y     = rsp_coord_ff[1];
   assign rsp_out_pos_z     = rsp_coord_ff[2];
   assign rsp_out_ang_x     = rsp_coord_ff[3];
   assign rsp_out_ang_y     = rsp_coord_ff[4];
   assign rsp_out_ang_z     = rsp_coord_ff[5];
   assign rsp_pose_source   = rsp_src_ff;
   assign rsp_still_playing = rsp_still_ff;

   // ---------------------------------------------------------------- checks
   // playback only ever runs over a full set of nodes
   a_play_full: assert property (@(posedge clock) disable iff (reset)
      playing_ff |-> (node_count_ff == NODES_FULL))
      else $error("playing with fewer than four nodes");

   // a wrapped phase is always cleared, never held above one
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_ONE)
      else $error("phase above 1.0");

   // a result never overwrites one that is still waiting for its transfer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("rsp register overwritten");

   // a store taken while the path is not full starts its write sweep at the first coordinate
   a_store_path: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_mode == MODE_STORE) && (node_count_ff < NODES_FULL))
      |=> (state_ff == ST_STORE) && (seq_ff == '0))
      else $error("store did not start its write sweep");

endmodule
